FILE: hw/rtl/nine_slice_layout_top_macros.svh
// assertion macros shared by the nine-slice layout checkers
// expects clk and rst in the scope of each use
`ifndef NINE_SLICE_LAYOUT_TOP_MACROS_SVH
`define NINE_SLICE_LAYOUT_TOP_MACROS_SVH

// same-cycle implication
`define NSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/nsl_pkg.sv
// shared types, constants and helpers for the nine-slice layout block
// no dependencies
package nsl_pkg;

  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic signed [19:0] coord_t;

  localparam slot_t SLOT_FIRST = SLOT_W'(0);
  localparam slot_t SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
  localparam slot_t SLOT_COUNT = SLOT_W'(NUM_SLOTS);

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LAYOUT = 1'b1;

  localparam logic [1:0] REG_TARGET_W = 2'd0;
  localparam logic [1:0] REG_TARGET_H = 2'd1;
  localparam logic [1:0] REG_ANCHOR_X = 2'd2;
  localparam logic [1:0] REG_ANCHOR_Y = 2'd3;

  localparam logic [1:0] BAND_LO  = 2'd0;
  localparam logic [1:0] BAND_MID = 2'd1;
  localparam logic [1:0] BAND_HI  = 2'd2;

  localparam logic [16:0] ANCHOR_ONE = 17'd65536;
  localparam logic [34:0] ROUND_HALF = 35'd32768;

  localparam logic signed [21:0] SAT_MAX = 22'sd524287;
  localparam logic signed [21:0] SAT_MIN = -22'sd524288;

  typedef struct packed {
    logic        present;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] shift_x;
    logic [15:0] shift_y;
  } part_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic calc_tgt;
    logic calc_mul;
  } axis_ctl_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_TGT   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ORG   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  function automatic logic [1:0] slot_col(input slot_t s);
    logic [1:0] c;
    case (s) inside
      4'd0, 4'd3, 4'd6: c = BAND_LO;
      4'd1, 4'd4, 4'd7: c = BAND_MID;
      default:          c = BAND_HI;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] slot_row(input slot_t s);
    logic [1:0] r;
    case (s) inside
      [4'd0:4'd2]: r = BAND_LO;
      [4'd3:4'd5]: r = BAND_MID;
      default:     r = BAND_HI;
    endcase
    return r;
  endfunction

  function automatic coord_t sat20(input logic signed [21:0] v);
    coord_t r;
    if (v > SAT_MAX) r = coord_t'(SAT_MAX);
    else if (v < SAT_MIN) r = coord_t'(SAT_MIN);
    else r = $signed(v[19:0]);
    return r;
  endfunction

endpackage

FILE: hw/rtl/nsl_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module nsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/nsl_axis.sv
// one layout axis: band maxima, clamped target size and anchored origin
// depends on nsl_pkg
module nsl_axis (
  input  logic              clk,
  input  nsl_pkg::axis_ctl_t ctl,
  input  logic              present,
  input  logic [1:0]        sel,
  input  logic [15:0]       size,
  input  logic [16:0]       treg,
  input  logic [16:0]       areg,
  output logic [17:0]       band_lo,
  output logic [17:0]       band_mid,
  output logic [17:0]       band_hi,
  output nsl_pkg::coord_t   origin
);
  import nsl_pkg::*;

  logic [15:0] bmax [3];
  logic [17:0] mid;
  logic [17:0] tgt;
  logic [34:0] prod;

  logic [17:0] natural;
  logic [17:0] min_size;
  logic [17:0] tgt_req;
  logic [17:0] tgt_calc;
  logic [16:0] anc;
  logic [34:0] rounded;

  always_comb begin
    natural  = {2'b0, bmax[0]} + {2'b0, bmax[1]} + {2'b0, bmax[2]};
    min_size = {2'b0, bmax[0]} + {2'b0, bmax[2]};
    // negative request selects the natural size
    tgt_req  = treg[16] ? natural : {2'b0, treg[15:0]};
    tgt_calc = (tgt_req < min_size) ? min_size : tgt_req;
    anc      = (areg > ANCHOR_ONE) ? ANCHOR_ONE : areg;
    rounded  = prod + ROUND_HALF;
    origin   = -$signed({1'b0, rounded[34:16]});
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < 3; i++) bmax[i] <= '0;
    end else if (ctl.take && present && (size > bmax[sel])) begin
      bmax[sel] <= size;
    end
    if (ctl.calc_tgt) begin
      tgt <= tgt_calc;
      mid <= tgt_calc - min_size;
    end
    if (ctl.calc_mul) begin
      prod <= {18'b0, anc} * {17'b0, tgt};
    end
  end

  assign band_lo  = {2'b0, bmax[0]};
  assign band_mid = mid;
  assign band_hi  = {2'b0, bmax[2]};

endmodule

FILE: hw/rtl/nine_slice_layout_top.sv
// nine-slice layout top level: part store, sequencer and rectangle output
// depends on nsl_pkg, nsl_ram, nsl_axis
//
// channel   dir  handshake                 payload
// item      in   item_valid / item_ready   command, part_index, part_*
// rect      out  rect_valid / rect_ready   slot, slot_present, rect_*, last
// cfg       in   cfg_write                 cfg_index, cfg_data
//
// a store word is written as it is accepted; a layout word runs nine
// ram reads for the band scan, one drain step, target, multiply and origin
// steps, then one ram read per rectangle, which output stalls can hold.
// the part ram has one read port, so scan and emit each walk nine entries.
// reset returns the config registers to their defaults and clears the
// per-slot written flags; an unwritten slot reads as zero. item_ready is
// high only while idle.
module nine_slice_layout_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 command,
  input  logic [3:0]           part_index,
  input  logic                 part_present,
  input  logic [15:0]          part_width,
  input  logic [15:0]          part_height,
  input  logic signed [15:0]   part_offset_x,
  input  logic signed [15:0]   part_offset_y,
  output logic                 rect_valid,
  input  logic                 rect_ready,
  output logic [3:0]           slot,
  output logic                 slot_present,
  output nsl_pkg::coord_t      rect_left,
  output nsl_pkg::coord_t      rect_top,
  output nsl_pkg::coord_t      rect_right,
  output nsl_pkg::coord_t      rect_bottom,
  output logic                 last,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data
);
  import nsl_pkg::*;

  state_t state, state_next;

  logic [16:0] target_width, target_height, anchor_x, anchor_y;
  logic [NUM_SLOTS-1:0] written;
  slot_t cnt;
  slot_t dslot;
  logic  scan_v;
  coord_t x_acc, y_acc;

  logic      accept, store_we, re, load_out;
  slot_t     raddr;
  part_t     wpart, rpart, entry;
  axis_ctl_t ctl;

  logic [17:0] bw_lo, bw_mid, bw_hi, bh_lo, bh_mid, bh_hi;
  coord_t      origin_x, origin_y;
  logic [1:0]  col, row;
  logic [17:0] bw_c, bh_r;
  logic signed [21:0] left_w, top_w, right_w, bottom_w;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign store_we   = accept && (command == CMD_STORE) && (part_index < SLOT_COUNT);

  assign wpart = '{present: part_present, width: part_width, height: part_height,
                   shift_x: part_offset_x, shift_y: part_offset_y};

  nsl_ram #(.WIDTH($bits(part_t)), .DEPTH(NUM_SLOTS)) u_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (part_index),
    .wdata (wpart),
    .re    (re),
    .raddr (raddr),
    .rdata (rpart)
  );

  // slot never written reads as all zero
  assign entry = written[dslot] ? rpart : '0;
  assign col   = slot_col(dslot);
  assign row   = slot_row(dslot);

  nsl_axis u_axis_x (
    .clk      (clk),
    .ctl      (ctl),
    .present  (entry.present),
    .sel      (col),
    .size     (entry.width),
    .treg     (target_width),
    .areg     (anchor_x),
    .band_lo  (bw_lo),
    .band_mid (bw_mid),
    .band_hi  (bw_hi),
    .origin   (origin_x)
  );

  nsl_axis u_axis_y (
    .clk      (clk),
    .ctl      (ctl),
    .present  (entry.present),
    .sel      (row),
    .size     (entry.height),
    .treg     (target_height),
    .areg     (anchor_y),
    .band_lo  (bh_lo),
    .band_mid (bh_mid),
    .band_hi  (bh_hi),
    .origin   (origin_y)
  );

  always_comb begin
    state_next   = state;
    re           = 1'b0;
    raddr        = cnt;
    load_out     = 1'b0;
    ctl          = '0;
    ctl.take     = scan_v;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_LAYOUT)) begin
          ctl.clear  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        re = 1'b1;
        if (cnt == SLOT_LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_TGT;
      ST_TGT: begin
        ctl.calc_tgt = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        ctl.calc_mul = 1'b1;
        state_next   = ST_ORG;
      end
      ST_ORG: begin
        re         = 1'b1;
        raddr      = SLOT_FIRST;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!rect_valid || rect_ready) begin
          load_out = 1'b1;
          if (dslot == SLOT_LAST) begin
            state_next = ST_IDLE;
          end else begin
            re    = 1'b1;
            raddr = dslot + SLOT_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (col)
      BAND_LO:  bw_c = bw_lo;
      BAND_MID: bw_c = bw_mid;
      default:  bw_c = bw_hi;
    endcase
    case (row)
      BAND_LO:  bh_r = bh_lo;
      BAND_MID: bh_r = bh_mid;
      default:  bh_r = bh_hi;
    endcase
    left_w   = $signed({{2{x_acc[19]}}, x_acc})
             + $signed({{6{entry.shift_x[15]}}, entry.shift_x});
    top_w    = $signed({{2{y_acc[19]}}, y_acc})
             + $signed({{6{entry.shift_y[15]}}, entry.shift_y});
    right_w  = left_w + $signed({4'b0, bw_c});
    bottom_w = top_w + $signed({4'b0, bh_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rect_valid    <= 1'b0;
      written       <= '0;
      scan_v        <= 1'b0;
      cnt           <= '0;
      dslot         <= '0;
      target_width  <= '1;
      target_height <= '1;
      anchor_x      <= '0;
      anchor_y      <= '0;
    end else begin
      state  <= state_next;
      scan_v <= (state == ST_SCAN);
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET_W: target_width  <= cfg_data;
          REG_TARGET_H: target_height <= cfg_data;
          REG_ANCHOR_X: anchor_x      <= cfg_data;
          REG_ANCHOR_Y: anchor_y      <= cfg_data;
          default: ;
        endcase
      end
      if (store_we) written[part_index] <= 1'b1;
      if (state == ST_IDLE) cnt <= '0;
      else if (state == ST_SCAN) cnt <= cnt + SLOT_W'(1);
      if (re) dslot <= raddr;
      if (load_out) rect_valid <= 1'b1;
      else if (rect_ready) rect_valid <= 1'b0;
    end
  end

  // position accumulators and output word
  always_ff @(posedge clk) begin
    if (state == ST_ORG) begin
      x_acc <= origin_x;
      y_acc <= origin_y;
    end else if (load_out) begin
      if (col == BAND_HI) begin
        x_acc <= origin_x;
        y_acc <= y_acc + $signed({2'b0, bh_r});
      end else begin
        x_acc <= x_acc + $signed({2'b0, bw_c});
      end
    end
    if (load_out) begin
      slot         <= dslot;
      slot_present <= entry.present;
      rect_left    <= sat20(left_w);
      rect_top     <= sat20(top_w);
      rect_right   <= sat20(right_w);
      rect_bottom  <= sat20(bottom_w);
      last         <= (dslot == SLOT_LAST);
    end
  end

endmodule

FILE: hw/rtl/nsl_chk.sv
// port-level checker for the nine-slice layout top, attached by bind
// depends on nsl_pkg and nine_slice_layout_top_macros.svh
`include "nine_slice_layout_top_macros.svh"

module nsl_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 command,
  input logic                 rect_valid,
  input logic                 rect_ready,
  input logic [3:0]           slot,
  input nsl_pkg::coord_t      rect_left,
  input nsl_pkg::coord_t      rect_top,
  input nsl_pkg::coord_t      rect_right,
  input nsl_pkg::coord_t      rect_bottom,
  input logic                 last
);
  import nsl_pkg::*;

  `NSL_ASSERT_NEXT(a_rect_hold, rect_valid && !rect_ready,
                   rect_valid && $stable(slot) && $stable(rect_left) && $stable(last),
                   "rect word changed while stalled")
  `NSL_ASSERT_NOW(a_last_slot, rect_valid, last == (slot == SLOT_LAST),
                  "last flag does not match final slot")
  `NSL_ASSERT_NOW(a_slot_range, rect_valid, slot <= SLOT_LAST, "slot out of range")
  `NSL_ASSERT_NOW(a_rect_order, rect_valid,
                  (rect_right >= rect_left) && (rect_bottom >= rect_top),
                  "rect edges out of order")
  `NSL_ASSERT_NEXT(a_layout_busy, item_valid && item_ready && (command == CMD_LAYOUT),
                   !item_ready, "layout word did not stall input")

endmodule

bind nine_slice_layout_top nsl_chk u_nsl_chk (.*);

FILE: tb/nine_slice_layout_top_test.sv
// testbench for the nine-slice layout block: directed and random part stores and layouts
// checked against an in-bench layout predictor; depends on nsl_pkg and nine_slice_layout_top
`timescale 1ns / 100ps

module nine_slice_layout_top_test;
  import nsl_pkg::*;

  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SHOWN_ERRORS  = 10;

  typedef longint band_set_t [3];

  typedef struct {
    slot_t  slot;
    logic   present;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    logic   last;
  } rect_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        command = CMD_STORE;
  logic [3:0]  part_index = '0;
  logic        part_present = 1'b0;
  logic [15:0] part_width = '0;
  logic [15:0] part_height = '0;
  logic signed [15:0] part_offset_x = '0;
  logic signed [15:0] part_offset_y = '0;
  logic        rect_valid;
  logic        rect_ready = 1'b0;
  logic [3:0]  slot;
  logic        slot_present;
  coord_t      rect_left;
  coord_t      rect_top;
  coord_t      rect_right;
  coord_t      rect_bottom;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_TARGET_W;
  logic [16:0] cfg_data = '0;

  // predictor copy of the registers and the part store
  logic [16:0] target_w_reg = 17'h1FFFF;
  logic [16:0] target_h_reg = 17'h1FFFF;
  logic [16:0] anchor_x_reg = '0;
  logic [16:0] anchor_y_reg = '0;
  part_t       sprite_parts [NUM_SLOTS];

  rect_word_t  pending_rects [$];
  int          error_count = 0;
  int          tx_idle_pct = IDLE_PCT;
  int          rx_idle_pct = IDLE_PCT;
  bit          hold_request = 1'b0;

  nine_slice_layout_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .part_index(part_index), .part_present(part_present),
    .part_width(part_width), .part_height(part_height),
    .part_offset_x(part_offset_x), .part_offset_y(part_offset_y),
    .rect_valid(rect_valid), .rect_ready(rect_ready),
    .slot(slot), .slot_present(slot_present),
    .rect_left(rect_left), .rect_top(rect_top),
    .rect_right(rect_right), .rect_bottom(rect_bottom), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------- layout predictor ----------------

  function automatic coord_t clamp_coord(input longint v);
    if (v > 524287) return coord_t'(524287);
    if (v < -524288) return coord_t'(-524288);
    return coord_t'(v);
  endfunction

  // band sizes along one axis and the anchored origin
  function automatic void axis_bands(input bit by_row, input logic [16:0] treg,
                                     input logic [16:0] areg,
                                     output band_set_t band, output longint origin);
    longint b [3];
    longint sz, req, mn, span, anc;
    int k;
    b = '{0, 0, 0};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      k = by_row ? i / 3 : i % 3;
      sz = by_row ? longint'(sprite_parts[i].height) : longint'(sprite_parts[i].width);
      if (sprite_parts[i].present && sz > b[k]) b[k] = sz;
    end
    mn = b[0] + b[2];
    req = longint'($signed(treg));
    span = (req >= 0) ? req : b[0] + b[1] + b[2];
    if (span < mn) span = mn;
    band[0] = b[0];
    band[1] = span - mn;
    band[2] = b[2];
    anc = (areg > 17'd65536) ? 65536 : longint'(areg);
    // round half away from zero, then negate
    origin = -((anc * span + 32768) >>> 16);
  endfunction

  function automatic void predict_layout();
    band_set_t bw, bh;
    longint ox, oy, x, y, left, top;
    rect_word_t r;
    int i;
    axis_bands(1'b0, target_w_reg, anchor_x_reg, bw, ox);
    axis_bands(1'b1, target_h_reg, anchor_y_reg, bh, oy);
    y = oy;
    for (int row = 0; row < 3; row++) begin
      x = ox;
      for (int col = 0; col < 3; col++) begin
        i = col + 3 * row;
        left = x + longint'($signed(sprite_parts[i].shift_x));
        top = y + longint'($signed(sprite_parts[i].shift_y));
        r.slot = slot_t'(i);
        r.present = sprite_parts[i].present;
        r.left = clamp_coord(left);
        r.top = clamp_coord(top);
        r.right = clamp_coord(left + bw[col]);
        r.bottom = clamp_coord(top + bh[row]);
        r.last = (i == NUM_SLOTS - 1);
        pending_rects.push_back(r);
        x += bw[col];
      end
      y += bh[row];
    end
  endfunction

  function automatic void absorb_word(input logic cmd, input logic [3:0] idx, input part_t p);
    if (cmd == CMD_LAYOUT) predict_layout();
    else if (idx < NUM_SLOTS) sprite_parts[idx] = p;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic part_t make_part(input logic present, input logic [15:0] w, h,
                                      input logic [15:0] sx, sy);
    part_t p;
    p.present = present;
    p.width = w;
    p.height = h;
    p.shift_x = sx;
    p.shift_y = sy;
    return p;
  endfunction

  function automatic logic [15:0] random_size();
    case ($urandom_range(3))
      0: return 16'($urandom_range(64));
      1: return 16'($urandom_range(1023));
      2: return 16'($urandom);
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] random_shift();
    case ($urandom_range(3))
      0, 1: return 16'($urandom_range(128)) - 16'd64;
      2: return 16'($urandom);
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic part_t random_part();
    return make_part($urandom_range(3) != 0, random_size(), random_size(),
                     random_shift(), random_shift());
  endfunction

  function automatic logic [16:0] random_target();
    case ($urandom_range(9))
      0, 1: return 17'h1FFFF;
      2: return 17'h10000 | 17'($urandom_range(65535));
      3: return 17'd0;
      4: return 17'd65535;
      5, 6: return 17'($urandom_range(2047));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [16:0] random_anchor();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return ANCHOR_ONE;
      2: return 17'd32768;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // valid stays high from one word to the next unless a gap is taken
  task automatic send_word(input logic cmd, input logic [3:0] idx, input part_t p);
    int gap;
    gap = 0;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
      gap = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    part_index <= idx;
    part_present <= p.present;
    part_width <= p.width;
    part_height <= p.height;
    part_offset_x <= p.shift_x;
    part_offset_y <= p.shift_y;
    do @(posedge clk); while (!item_ready);
    absorb_word(cmd, idx, p);
  endtask

  task automatic send_layout();
    send_word(CMD_LAYOUT, 4'($urandom_range(15)), random_part());
  endtask

  // drop valid, wait for every rectangle, then let the block fall idle
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_W: target_w_reg = value;
      REG_TARGET_H: target_h_reg = value;
      REG_ANCHOR_X: anchor_x_reg = value;
      default:      anchor_y_reg = value;
    endcase
  endtask

  task automatic apply_setting(input logic [16:0] tw, th, ax, ay);
    settle();
    write_reg(REG_TARGET_W, tw);
    write_reg(REG_TARGET_H, th);
    write_reg(REG_ANCHOR_X, ax);
    write_reg(REG_ANCHOR_Y, ay);
  endtask

  task automatic random_words(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) send_layout();
      else if ($urandom_range(19) == 0)
        send_word(CMD_STORE, 4'($urandom_range(9, 15)), random_part());
      else
        send_word(CMD_STORE, 4'($urandom_range(NUM_SLOTS - 1)), random_part());
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_empty_layout();
    send_layout();
  endtask

  task automatic test_part_extremes();
    send_word(CMD_STORE, 4'd0, make_part(1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000));
    send_word(CMD_STORE, 4'd8, make_part(1'b1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF));
    send_word(CMD_STORE, 4'd4, make_part(1'b1, 16'd1, 16'd1, 16'h0000, 16'h0000));
    // absent part keeps its geometry but adds nothing to the bands
    send_word(CMD_STORE, 4'd2, make_part(1'b0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000));
    // slots past eight are dropped
    send_word(CMD_STORE, 4'd15, make_part(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(CMD_STORE, 4'd9, make_part(1'b1, 16'hAAAA, 16'h5555, 16'h1234, 16'hEDCB));
    send_layout();
  endtask

  task automatic test_target_modes();
    send_word(CMD_STORE, 4'd0, make_part(1'b1, 16'd16, 16'd48, 16'h7FFF, 16'h8000));
    send_word(CMD_STORE, 4'd8, make_part(1'b0, 16'd5, 16'd7, 16'h0010, 16'hFFF0));
    apply_setting(17'd0, 17'd0, 17'd0, 17'd0);
    send_layout();
    apply_setting(17'd65535, 17'd65535, 17'd0, 17'd0);
    send_layout();
    apply_setting(17'h10000, 17'h10000, 17'd0, 17'd0);
    send_layout();
  endtask

  task automatic test_anchor_modes();
    send_word(CMD_STORE, 4'd0, make_part(1'b0, 16'd16, 16'd48, 16'h0000, 16'h0000));
    // half of an odd size rounds away from zero
    apply_setting(17'd3, 17'd3, 17'd32768, 17'd32768);
    send_layout();
    apply_setting(17'd65535, 17'h1FFFF, ANCHOR_ONE, ANCHOR_ONE);
    send_layout();
    apply_setting(17'd40000, 17'd777, 17'h1FFFF, 17'h10001);
    send_layout();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      apply_setting(random_target(), random_target(), random_anchor(), random_anchor());
      random_words(76);
    end
  endtask

  task automatic test_steady_stream();
    apply_setting(random_target(), random_target(), random_anchor(), random_anchor());
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_words(60);
    settle();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  task automatic test_output_backpressure();
    apply_setting(17'h1FFFF, 17'd65535, 17'd32768, 17'd65536);
    hold_request = 1'b1;
    send_layout();
    random_words(39);
  endtask

  // ---------------- rectangle sink and checker ----------------

  initial begin : rect_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rect_ready <= 1'b0;
      end else begin
        rect_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : rect_check
    rect_word_t want;
    bit bad;
    if (!rst && rect_valid && rect_ready) begin
      if (pending_rects.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected rect word: slot %0d", slot);
      end else begin
        want = pending_rects.pop_front();
        bad = (slot !== want.slot) || (slot_present !== want.present) ||
              (rect_left !== want.left) || (rect_top !== want.top) ||
              (rect_right !== want.right) || (rect_bottom !== want.bottom) ||
              (last !== want.last);
        if (bad) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("rect mismatch: exp slot %0d p %0d l %0d t %0d r %0d b %0d last %0d",
                     want.slot, want.present, want.left, want.top, want.right,
                     want.bottom, want.last);
            $display("               got slot %0d p %0d l %0d t %0d r %0d b %0d last %0d",
                     slot, slot_present, rect_left, rect_top, rect_right,
                     rect_bottom, last);
          end
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) sprite_parts[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_layout();
    test_part_extremes();
    test_target_modes();
    test_anchor_modes();
    test_random_traffic();
    test_steady_stream();
    test_output_backpressure();
    settle();
    error_count += pending_rects.size();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/nsl_pkg.sv
hw/rtl/nsl_ram.sv
hw/rtl/nsl_axis.sv
hw/rtl/nine_slice_layout_top.sv
hw/rtl/nsl_chk.sv
tb/nine_slice_layout_top_test.sv
